// ----- src/rsfd_pkg.sv -----
// Shared types and constants for the radar sensor frame decoder.
package rsfd_pkg;

    localparam int unsigned FrameKeep  = 7;
    localparam int unsigned PosWidth   = 3;
    localparam int unsigned DataWidth  = 8;
    localparam int unsigned StateWidth = 3;
    localparam int unsigned MTdataWidth = 16;

    localparam logic [7:0] BYTE_START  = 8'h53;
    localparam logic [7:0] BYTE_HEADER = 8'h59;
    localparam logic [7:0] BYTE_TAIL0  = 8'h54;
    localparam logic [7:0] BYTE_TAIL1  = 8'h43;
    localparam logic [7:0] LEN_HIGH    = 8'h00;
    localparam logic [7:0] LEN_LOW     = 8'h01;

    localparam logic [7:0] CTL_HUMAN   = 8'h80;
    localparam logic [7:0] CTL_FALL    = 8'h83;
    localparam logic [7:0] CMD_PRES    = 8'h01;
    localparam logic [7:0] CMD_PRES_Q  = 8'h81;
    localparam logic [7:0] CMD_MOTION  = 8'h02;
    localparam logic [7:0] CMD_MOTN_Q  = 8'h82;
    localparam logic [7:0] CMD_RATE    = 8'h03;
    localparam logic [7:0] CMD_FALL    = 8'h01;

    localparam logic [7:0] VAL_0 = 8'h00;
    localparam logic [7:0] VAL_1 = 8'h01;
    localparam logic [7:0] VAL_2 = 8'h02;

    localparam logic [StateWidth-1:0] ST_UNSET    = 3'd0;
    localparam logic [StateWidth-1:0] ST_NO_ONE   = 3'd1;
    localparam logic [StateWidth-1:0] ST_SOMEONE  = 3'd2;
    localparam logic [StateWidth-1:0] ST_NONE     = 3'd3;
    localparam logic [StateWidth-1:0] ST_STILL    = 3'd4;
    localparam logic [StateWidth-1:0] ST_ACTIVE   = 3'd5;
    localparam logic [StateWidth-1:0] ST_NOT_FALL = 3'd6;
    localparam logic [StateWidth-1:0] ST_FALLING  = 3'd7;

    typedef enum logic [1:0] {
        HDR_IDLE   = 2'd0,
        HDR_START  = 2'd1,
        HDR_HEADER = 2'd2
    } hdr_phase_t;

    typedef enum logic [1:0] {
        TAIL_OPEN   = 2'd0,
        TAIL_MARK   = 2'd1,
        TAIL_CLOSED = 2'd2
    } tail_phase_t;

    typedef enum logic {
        REPORT_STATE = 1'b0,
        REPORT_RATE  = 1'b1
    } report_kind_t;

    typedef logic [DataWidth-1:0] frame_t [FrameKeep];

    typedef struct packed {
        logic                  hit;
        report_kind_t          kind;
        logic [StateWidth-1:0] state;
        logic [DataWidth-1:0]  rate;
    } decode_t;

    typedef struct packed {
        report_kind_t          kind;
        logic [StateWidth-1:0] state;
        logic [DataWidth-1:0]  rate;
    } result_t;

endpackage

// ----- src/rsfd_frame_decode.sv -----
// Decode of a closed frame into a state or movement rate update.
module rsfd_frame_decode import rsfd_pkg::*; (
    input  frame_t                frame,
    input  logic [StateWidth-1:0] last_state,
    input  logic [DataWidth-1:0]  last_rate,
    output decode_t               dec
);

    logic [DataWidth-1:0] ctl;
    logic [DataWidth-1:0] cmd;
    logic [DataWidth-1:0] val;
    logic                 framed;

    assign ctl = frame[2];
    assign cmd = frame[3];
    assign val = frame[6];
    assign framed = (frame[0] == BYTE_START) && (frame[1] == BYTE_HEADER)
                 && (frame[4] == LEN_HIGH) && (frame[5] == LEN_LOW);

    always_comb begin
        dec.hit   = 1'b0;
        dec.kind  = REPORT_STATE;
        dec.state = last_state;
        dec.rate  = last_rate;
        if (framed) begin
            if (ctl == CTL_HUMAN) begin
                if (cmd == CMD_PRES || cmd == CMD_PRES_Q) begin
                    dec.hit = 1'b1;
                    if (val == VAL_0) begin
                        dec.state = ST_NO_ONE;
                    end else if (val == VAL_1) begin
                        dec.state = ST_SOMEONE;
                    end
                end else if (cmd == CMD_MOTION || cmd == CMD_MOTN_Q) begin
                    dec.hit = 1'b1;
                    if (val == VAL_0) begin
                        dec.state = ST_NONE;
                    end else if (val == VAL_1) begin
                        dec.state = ST_STILL;
                    end else if (val == VAL_2) begin
                        dec.state = ST_ACTIVE;
                    end
                end else if (cmd == CMD_RATE) begin
                    dec.hit  = 1'b1;
                    dec.kind = REPORT_RATE;
                    dec.rate = val;
                end
            end else if (ctl == CTL_FALL && cmd == CMD_FALL) begin
                dec.hit = 1'b1;
                if (val == VAL_0) begin
                    dec.state = ST_NOT_FALL;
                end else if (val == VAL_1) begin
                    dec.state = ST_FALLING;
                end
            end
        end
    end

endmodule

// ----- src/radar_sensor_frame_decoder_core.sv -----
// Top level of the radar sensor frame decoder.
//
// Input channel s_*: one received sensor byte per request in s_tdata.
// Output channel m_*: one report per closed frame that carries a known
// message. m_tuser gives the report kind (0 state, 1 movement rate);
// m_tdata carries the last state code and the last movement rate.
// A 0x53 opens a frame, 0x59 marks the header, 0x54 then 0x43 close it.
// Frames with an unknown header, length or message give no report.
// Each byte is handled in the cycle it is accepted; the report of a frame it
// closes is registered. One byte is taken every cycle while s_tready is high.
// Results pass through an output register backed by one skid register, so
// bytes keep flowing while one report waits; s_tready drops only when both
// hold a report that the receiver has not taken.
// Reset (aresetn low at a rising edge) clears the kept frame bytes, the
// framing phases, the last state and rate, and empties both result
// registers. The first byte after reset, unless it is a start byte, decodes
// the cleared frame, which gives no report.
module radar_sensor_frame_decoder_core import rsfd_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [DataWidth-1:0]   s_tdata,   // [7:0] rx_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [MTdataWidth-1:0] m_tdata,   // [2:0] state_code, [10:3] motion_rate
    output logic [0:0]             m_tuser    // [0] report_kind
);

    frame_t                frame_reg, frame_next;
    logic [PosWidth-1:0]   wpos_reg, wpos_next;
    logic                  started_reg, started_next;
    hdr_phase_t            hdr_reg, hdr_next;
    tail_phase_t           tail_reg, tail_next;
    logic [StateWidth-1:0] last_state_reg, last_state_next;
    logic [DataWidth-1:0]  last_rate_reg, last_rate_next;

    result_t out_reg, out_next;
    logic    out_valid_reg, out_valid_next;
    result_t skid_reg, skid_next;
    logic    skid_valid_reg, skid_valid_next;

    decode_t dec;
    logic    s_accept;
    logic    m_pop;
    logic    push;
    result_t push_data;

    assign s_tready = !skid_valid_reg;
    assign s_accept = s_tvalid && s_tready;
    assign m_pop    = out_valid_reg && m_tready;

    always_comb begin
        frame_next      = frame_reg;
        wpos_next       = wpos_reg;
        started_next    = started_reg;
        hdr_next        = hdr_reg;
        tail_next       = tail_reg;
        if (s_accept) begin
            if (s_tdata == BYTE_START && hdr_reg == HDR_IDLE) begin
                started_next  = 1'b1;
                hdr_next      = HDR_START;
                tail_next     = TAIL_OPEN;
                frame_next[0] = s_tdata;
                wpos_next     = PosWidth'(1);
            end else if (started_reg) begin
                if (wpos_reg < PosWidth'(FrameKeep)) begin
                    frame_next[wpos_reg] = s_tdata;
                    wpos_next            = wpos_reg + PosWidth'(1);
                end
                if (s_tdata == BYTE_HEADER && hdr_reg == HDR_START) begin
                    hdr_next = HDR_HEADER;
                end
                if (s_tdata == BYTE_TAIL0 && hdr_reg == HDR_HEADER) begin
                    tail_next = TAIL_MARK;
                end
                if (s_tdata == BYTE_TAIL1 && tail_reg == TAIL_MARK) begin
                    tail_next = TAIL_CLOSED;
                    hdr_next  = HDR_IDLE;
                end
            end
        end
    end

    rsfd_frame_decode u_decode (
        .frame      (frame_next),
        .last_state (last_state_reg),
        .last_rate  (last_rate_reg),
        .dec        (dec)
    );

    tail_phase_t tail_final;
    always_comb begin
        tail_final      = tail_next;
        last_state_next = last_state_reg;
        last_rate_next  = last_rate_reg;
        push            = 1'b0;
        if (s_accept && tail_next == TAIL_CLOSED) begin
            tail_final = TAIL_OPEN;
            if (dec.hit) begin
                push            = 1'b1;
                last_state_next = dec.state;
                last_rate_next  = dec.rate;
            end
        end
        push_data.kind  = dec.kind;
        push_data.state = last_state_next;
        push_data.rate  = last_rate_next;
    end

    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || m_pop) begin
            if (skid_valid_reg) begin
                out_next       = skid_reg;
                out_valid_next = 1'b1;
                skid_next       = push_data;
                skid_valid_next = push;
            end else begin
                out_next        = push_data;
                out_valid_next  = push;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < FrameKeep; i++) begin
                frame_reg[i] <= '0;
            end
            wpos_reg       <= '0;
            started_reg    <= 1'b0;
            hdr_reg        <= HDR_IDLE;
            tail_reg       <= TAIL_CLOSED;
            last_state_reg <= ST_UNSET;
            last_rate_reg  <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            frame_reg      <= frame_next;
            wpos_reg       <= wpos_next;
            started_reg    <= started_next;
            hdr_reg        <= hdr_next;
            tail_reg       <= tail_final;
            last_state_reg <= last_state_next;
            last_rate_reg  <= last_rate_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tuser[0] = out_reg.kind;
    assign m_tdata    = {(MTdataWidth - DataWidth - StateWidth)'(0), out_reg.rate,
                         out_reg.state};

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a report while output register is empty");

    a_start_opens: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tdata == BYTE_START && hdr_reg == HDR_IDLE)
        |=> (tail_reg == TAIL_OPEN && wpos_reg == PosWidth'(1) && started_reg))
        else $error("start byte did not open a new frame");

    a_wpos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wpos_reg <= PosWidth'(FrameKeep))
        else $error("write position beyond kept frame bytes");

    a_no_report_without_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_accept && !out_valid_reg) |=> !out_valid_reg)
        else $error("report appeared without an accepted byte");

endmodule

// ----- tb/radar_sensor_frame_decoder_core_tb.sv -----
// Testbench for the radar sensor frame decoder: byte stream stimulus with a report scoreboard.
`timescale 1ns / 1ps

module radar_sensor_frame_decoder_core_tb import rsfd_pkg::*;;

    class radar_report_board;
        logic [DataWidth-1:0]  kept [FrameKeep];
        logic [PosWidth-1:0]   wpos;
        bit                    started;
        hdr_phase_t            hdr;
        tail_phase_t           tail;
        logic [StateWidth-1:0] last_state;
        logic [DataWidth-1:0]  last_rate;
        result_t               expected_reports [$];
        int                    errors;

        function new();
            foreach (kept[i]) kept[i] = '0;
            wpos = '0;
            started = 1'b0;
            hdr = HDR_IDLE;
            tail = TAIL_CLOSED;
            last_state = ST_UNSET;
            last_rate = '0;
            errors = 0;
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function bit decode_kept(output report_kind_t kind);
            logic [DataWidth-1:0] ctl;
            logic [DataWidth-1:0] cmd;
            logic [DataWidth-1:0] val;
            ctl = kept[2];
            cmd = kept[3];
            val = kept[6];
            kind = REPORT_STATE;
            if (kept[0] != BYTE_START || kept[1] != BYTE_HEADER) return 1'b0;
            if (kept[4] != LEN_HIGH || kept[5] != LEN_LOW) return 1'b0;
            if (ctl == CTL_HUMAN) begin
                if (cmd == CMD_PRES || cmd == CMD_PRES_Q) begin
                    if (val == VAL_0) last_state = ST_NO_ONE;
                    else if (val == VAL_1) last_state = ST_SOMEONE;
                    return 1'b1;
                end
                if (cmd == CMD_MOTION || cmd == CMD_MOTN_Q) begin
                    if (val == VAL_0) last_state = ST_NONE;
                    else if (val == VAL_1) last_state = ST_STILL;
                    else if (val == VAL_2) last_state = ST_ACTIVE;
                    return 1'b1;
                end
                if (cmd == CMD_RATE) begin
                    last_rate = val;
                    kind = REPORT_RATE;
                    return 1'b1;
                end
                return 1'b0;
            end
            if (ctl == CTL_FALL && cmd == CMD_FALL) begin
                if (val == VAL_0) last_state = ST_NOT_FALL;
                else if (val == VAL_1) last_state = ST_FALLING;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_byte(logic [DataWidth-1:0] b);
            report_kind_t kind;
            result_t      r;
            if (b == BYTE_START && hdr == HDR_IDLE) begin
                started = 1'b1;
                hdr = HDR_START;
                tail = TAIL_OPEN;
                kept[0] = b;
                wpos = PosWidth'(1);
            end else if (started) begin
                if (wpos < FrameKeep) begin
                    kept[wpos] = b;
                    wpos = wpos + 1'b1;
                end
                if (b == BYTE_HEADER && hdr == HDR_START) hdr = HDR_HEADER;
                if (b == BYTE_TAIL0 && hdr == HDR_HEADER) tail = TAIL_MARK;
                if (b == BYTE_TAIL1 && tail == TAIL_MARK) begin
                    tail = TAIL_CLOSED;
                    hdr = HDR_IDLE;
                end
            end
            if (tail == TAIL_CLOSED) begin
                tail = TAIL_OPEN;
                if (decode_kept(kind)) begin
                    r.kind = kind;
                    r.state = last_state;
                    r.rate = last_rate;
                    expected_reports.push_back(r);
                end
            end
        endfunction

        function void flag(string field, int exp_val, int act_val);
            errors++;
            if (errors <= 10)
                $display("mismatch at %0t: %s expected %0d got %0d", $realtime, field,
                         exp_val, act_val);
        endfunction

        function void check_report(logic kind_bit, logic [MTdataWidth-1:0] data);
            result_t exp_r;
            if (expected_reports.size() == 0) begin
                flag("unexpected report, m_tdata", 0, data);
                return;
            end
            exp_r = expected_reports.pop_front();
            if (kind_bit !== exp_r.kind) flag("report_kind", exp_r.kind, kind_bit);
            if (data[2:0] !== exp_r.state) flag("state_code", exp_r.state, data[2:0]);
            if (data[10:3] !== exp_r.rate) flag("motion_rate", exp_r.rate, data[10:3]);
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [DataWidth-1:0]   s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [MTdataWidth-1:0] m_tdata;
    logic [0:0]             m_tuser;

    radar_report_board sb;
    int bytes_sent = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_cycles = 0;

    radar_sensor_frame_decoder_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_byte(s_tdata);
            if (m_tvalid && m_tready) sb.check_report(m_tuser[0], m_tdata);
        end
    end

    task automatic send_byte(logic [DataWidth-1:0] b);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_frame(logic [7:0] ctl, logic [7:0] cmd, logic [7:0] val,
                              logic [7:0] len_hi, logic [7:0] len_lo, int extra);
        send_byte(BYTE_START);
        send_byte(BYTE_HEADER);
        send_byte(ctl);
        send_byte(cmd);
        send_byte(len_hi);
        send_byte(len_lo);
        send_byte(val);
        send_byte(8'($urandom));
        repeat (extra) send_byte(8'($urandom));
        send_byte(BYTE_TAIL0);
        send_byte(BYTE_TAIL1);
    endtask

    task automatic send_good_frame();
        logic [7:0] ctl;
        logic [7:0] cmd;
        logic [7:0] val;
        logic [7:0] len_hi;
        logic [7:0] len_lo;
        int         pick;
        pick = $urandom_range(99);
        ctl = (pick < 45) ? CTL_HUMAN : (pick < 80) ? CTL_FALL : 8'($urandom);
        if (ctl == CTL_HUMAN) begin
            case ($urandom_range(5))
                0: cmd = CMD_PRES;
                1: cmd = CMD_PRES_Q;
                2: cmd = CMD_MOTION;
                3: cmd = CMD_MOTN_Q;
                4: cmd = CMD_RATE;
                default: cmd = 8'($urandom);
            endcase
        end else begin
            cmd = ($urandom_range(9) < 8) ? CMD_FALL : 8'($urandom);
        end
        val = ($urandom_range(9) < 6) ? 8'($urandom_range(3)) : 8'($urandom);
        len_hi = ($urandom_range(19) == 0) ? 8'($urandom) : LEN_HIGH;
        len_lo = ($urandom_range(19) == 0) ? 8'($urandom) : LEN_LOW;
        send_frame(ctl, cmd, val, len_hi, len_lo,
                   ($urandom_range(9) == 0) ? $urandom_range(1, 4) : 0);
    endtask

    task automatic send_random_burst();
        int pick;
        pick = $urandom_range(99);
        if (pick < 72) begin
            send_good_frame();
        end else if (pick < 80) begin
            send_byte(BYTE_START);
            send_byte(BYTE_HEADER);
            repeat ($urandom_range(2)) send_byte(8'($urandom));
            send_byte(BYTE_TAIL0);
            send_byte(BYTE_TAIL1);
        end else if (pick < 92) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
        end else begin
            send_byte(BYTE_START);
            if ($urandom_range(1)) send_byte(BYTE_HEADER);
            repeat ($urandom_range(3, 8)) send_byte(8'($urandom));
        end
    endtask

    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // stray bytes before any start byte
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(BYTE_TAIL1);
        // long rate frame, short frame over stale slots, falling report
        send_frame(CTL_HUMAN, CMD_RATE, 8'hFF, LEN_HIGH, LEN_LOW, 1);
        send_byte(BYTE_START);
        send_byte(BYTE_HEADER);
        send_byte(BYTE_TAIL0);
        send_byte(BYTE_TAIL1);
        send_frame(CTL_FALL, CMD_FALL, VAL_1, LEN_HIGH, LEN_LOW, 0);

        while (bytes_sent < 300) send_random_burst();

        // hold off the receiver long enough for the block to fill and stall
        s_tvalid <= 1'b0;
        @(negedge aclk);
        hold_cycles = 150;
        @(posedge aclk);
        repeat (15) send_frame(CTL_HUMAN, CMD_PRES, 8'($urandom_range(2)), LEN_HIGH, LEN_LOW, 0);

        idle_pct = 85;
        stall_pct = 0;
        while (bytes_sent < 600) send_random_burst();
        idle_pct = 0;
        stall_pct = 85;
        while (bytes_sent < 900) send_random_burst();
        idle_pct = 7;
        stall_pct = 7;
        while (bytes_sent < 1150) send_random_burst();
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
